[rtl/pwsm_pkg.sv]
// Shared constants and types for the pulse-width speed meter.
package pwsm_pkg;

    localparam int CAP_W          = 16;
    localparam int CONST_W        = 20;
    localparam int REG_W          = 16;
    localparam int SPEED_W        = 21;
    localparam int WIDTH_W        = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 20;
    localparam int S_TDATA_W      = 24;
    localparam int S_TUSER_W      = 1;
    localparam int M_TDATA_W      = 24;
    localparam int M_TUSER_W      = 2;
    localparam int FILTER_LEN_DEF = 4;
    localparam int DIV_NUM_W_DEF  = 20;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_CONST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_SPAN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GLITCH_THR  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 2'd3;

    localparam logic [CONST_W-1:0] SPEED_CONST_RST = 20'd50000;
    localparam logic [REG_W-1:0]   WRAP_SPAN_RST   = 16'd65535;
    localparam logic [REG_W-1:0]   GLITCH_THR_RST  = 16'd5;
    localparam logic [REG_W-1:0]   TIMEOUT_RST     = 16'd65535;

    localparam logic OP_CAPTURE  = 1'b0;
    localparam logic OP_OVERFLOW = 1'b1;

    typedef logic signed [SPEED_W-1:0] t_speed;

endpackage

[rtl/pwsm_div.sv]
// Restoring serial divider that produces one quotient bit per cycle.
module pwsm_div #(
    parameter int NUM_W = pwsm_pkg::DIV_NUM_W_DEF,
    parameter int DEN_W = pwsm_pkg::WIDTH_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CMP_W = (NUM_W + 1 > DEN_W) ? NUM_W + 1 : DEN_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [NUM_W:0]   trial;
    logic [CMP_W-1:0] trial_x;
    logic [CMP_W-1:0] den_x;
    logic [CMP_W-1:0] diff;
    logic             ge;
    logic [NUM_W-1:0] n_rem;
    logic [NUM_W-1:0] n_num;

    always_comb begin
        trial   = {r_rem, r_num[NUM_W-1]};
        trial_x = CMP_W'(trial);
        den_x   = CMP_W'(r_den);
        ge      = (trial_x >= den_x);
        diff    = trial_x - den_x;
        n_rem   = ge ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
        n_num   = {r_num[NUM_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
                r_num  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_num <= n_num;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

[rtl/pulse_width_speed_meter.sv]
// Overflow ticks and rising captures give their result in the cycle after the transfer and,
// with the result side ready, can follow back to back.
// A falling capture steps through S_MUL, S_WIDTH, S_DIV_SPD, S_ACC, and S_AVG_MUL and S_AVG
// when it closes a filter group; the serial divider computes one quotient bit of the speed per cycle.
// One item is in work at a time. Synchronous active-low reset restores the register
// defaults and clears measurement and filter state but r_cap, r_prod, r_acc_mag, r_avg_q.
module pulse_width_speed_meter #(
    parameter int FILTER_LEN = pwsm_pkg::FILTER_LEN_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tdata: capture_value[15:0], direction_level[16], zero pad [23:17]
    input  logic [pwsm_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // tuser: opcode[0]
    input  logic [pwsm_pkg::S_TUSER_W-1:0]      s_axis_tuser,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: speed[20:0], zero pad [23:21]
    output logic [pwsm_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // tuser: speed_updated[0], timed_out[1]
    output logic [pwsm_pkg::M_TUSER_W-1:0]      m_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                i_cfg_we,
    input  logic [pwsm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pwsm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import pwsm_pkg::*;

    localparam int LEN_W    = $clog2(FILTER_LEN);
    localparam int MAG_W    = CONST_W + LEN_W;
    localparam int SUM_W    = SPEED_W + LEN_W;
    localparam int ACC_W    = SUM_W + 1;
    localparam int CNT_W    = $clog2(FILTER_LEN + 1);
    localparam int RECIP_SH = MAG_W + LEN_W;
    localparam int PROD_W   = MAG_W + RECIP_SH;

    // Rounded-up reciprocal of FILTER_LEN; exact for every magnitude below 2**MAG_W.
    localparam longint RECIP_L = ((longint'(1) << RECIP_SH) + longint'(FILTER_LEN - 1))
                                 / longint'(FILTER_LEN);
    localparam logic [RECIP_SH-1:0] RECIP = RECIP_SH'(RECIP_L);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_MUL     = 3'd1;
    localparam logic [2:0] S_WIDTH   = 3'd2;
    localparam logic [2:0] S_DIV_SPD = 3'd3;
    localparam logic [2:0] S_ACC     = 3'd4;
    localparam logic [2:0] S_AVG_MUL = 3'd5;
    localparam logic [2:0] S_AVG     = 3'd6;

    // Configuration registers
    logic [CONST_W-1:0] r_speed_const;
    logic [REG_W-1:0]   r_wrap_span;
    logic [REG_W-1:0]   r_glitch_thr;
    logic [REG_W-1:0]   r_timeout;

    // Measurement and filter state
    logic [2:0]              r_state;
    logic                    r_phase_falling;
    logic [CAP_W-1:0]        r_first_stamp;
    logic                    r_dir_backward;
    logic [REG_W-1:0]        r_ovf_cnt;
    logic [CAP_W-1:0]        r_cap;
    logic [WIDTH_W-1:0]      r_prod;
    logic signed [SUM_W-1:0] r_sum;
    t_speed                  r_single;
    logic [CNT_W-1:0]        r_cnt;
    t_speed                  r_prev_avg;
    logic                    r_primed;
    t_speed                  r_pub;
    logic                    r_avg_neg;
    logic [MAG_W-1:0]        r_acc_mag;
    logic [CONST_W-1:0]      r_avg_q;

    // Output register
    logic   r_out_valid;
    t_speed r_out_speed;
    logic   r_out_upd;
    logic   r_out_to;

    logic               in_op;
    logic [CAP_W-1:0]   in_cap;
    logic               in_dir;
    logic               in_xfer;

    logic [WIDTH_W-1:0] width_base;
    logic [WIDTH_W-1:0] width_raw;
    logic [WIDTH_W-1:0] width;

    logic               div_start;
    logic [CONST_W-1:0] div_num;
    logic [WIDTH_W-1:0] div_den;
    logic               div_busy;
    logic               div_done;
    logic [CONST_W-1:0] div_quot;

    t_speed                  quot_s;
    t_speed                  single;
    t_speed                  avg_q_s;
    t_speed                  avg;
    logic [PROD_W-1:0]       avg_prod;
    logic [CNT_W-1:0]        n_cnt;
    logic                    group_end;
    logic signed [ACC_W-1:0] acc;
    logic                    acc_neg;
    logic [ACC_W-1:0]        acc_mag;
    logic signed [SPEED_W:0] chk;
    logic [SPEED_W:0]        chk_mag;
    logic                    pass;

    assign in_op   = s_axis_tuser[0];
    assign in_cap  = s_axis_tdata[CAP_W-1:0];
    assign in_dir  = s_axis_tdata[CAP_W];
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // The output register is free at every transfer, so a result never waits on it.
    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);

    always_comb begin
        width_base = WIDTH_W'(r_wrap_span) - WIDTH_W'(r_first_stamp) + WIDTH_W'(r_cap);
        if (r_ovf_cnt == '0) begin
            width_raw = WIDTH_W'(r_cap) - WIDTH_W'(r_first_stamp);
        end else if (r_ovf_cnt == REG_W'(1)) begin
            width_raw = width_base;
        end else begin
            width_raw = width_base + r_prod;
        end
        width = (width_raw == '0) ? WIDTH_W'(1) : width_raw;
    end

    always_comb begin
        quot_s  = t_speed'({1'b0, div_quot});
        single  = r_dir_backward ? -quot_s : quot_s;

        avg_prod = PROD_W'(r_acc_mag) * PROD_W'(RECIP);
        avg_q_s  = t_speed'({1'b0, r_avg_q});
        avg      = r_avg_neg ? -avg_q_s : avg_q_s;

        n_cnt     = r_cnt + 1'b1;
        group_end = (n_cnt == CNT_W'(FILTER_LEN));

        // On a primed filter the newest sample gives way to the previous average.
        if (r_primed) begin
            acc = ACC_W'(r_sum) - ACC_W'(r_single) + ACC_W'(r_prev_avg);
        end else begin
            acc = ACC_W'(r_sum) + ACC_W'(r_prev_avg);
        end
        acc_neg = acc[ACC_W-1];
        acc_mag = acc_neg ? ACC_W'(-acc) : ACC_W'(acc);

        chk     = (SPEED_W + 1)'(avg) + (SPEED_W + 1)'(r_prev_avg);
        chk_mag = chk[SPEED_W] ? (SPEED_W + 1)'(-chk) : (SPEED_W + 1)'(chk);
        pass    = (chk_mag >= (SPEED_W + 1)'(r_glitch_thr));

        div_start = (r_state == S_WIDTH);
        div_num   = r_speed_const;
        div_den   = width;
    end

    pwsm_div #(
        .NUM_W (CONST_W),
        .DEN_W (WIDTH_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_const   <= SPEED_CONST_RST;
            r_wrap_span     <= WRAP_SPAN_RST;
            r_glitch_thr    <= GLITCH_THR_RST;
            r_timeout       <= TIMEOUT_RST;
            r_state         <= S_IDLE;
            r_phase_falling <= 1'b0;
            r_first_stamp   <= '0;
            r_dir_backward  <= 1'b0;
            r_ovf_cnt       <= '0;
            r_sum           <= '0;
            r_single        <= '0;
            r_cnt           <= '0;
            r_prev_avg      <= '0;
            r_primed        <= 1'b0;
            r_pub           <= '0;
            r_avg_neg       <= 1'b0;
            r_out_valid     <= 1'b0;
            r_out_speed     <= '0;
            r_out_upd       <= 1'b0;
            r_out_to        <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SPEED_CONST: r_speed_const <= i_cfg_data[CONST_W-1:0];
                    REG_WRAP_SPAN:   r_wrap_span   <= i_cfg_data[REG_W-1:0];
                    REG_GLITCH_THR:  r_glitch_thr  <= i_cfg_data[REG_W-1:0];
                    REG_TIMEOUT:     r_timeout     <= i_cfg_data[REG_W-1:0];
                    default:         r_timeout     <= r_timeout;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (in_op == OP_OVERFLOW) begin
                            r_out_valid <= 1'b1;
                            r_out_upd   <= 1'b0;
                            if (r_ovf_cnt < r_timeout) begin
                                r_ovf_cnt   <= r_ovf_cnt + 1'b1;
                                r_out_speed <= r_pub;
                                r_out_to    <= 1'b0;
                            end else begin
                                r_ovf_cnt   <= '0;
                                r_pub       <= '0;
                                r_out_speed <= '0;
                                r_out_to    <= 1'b1;
                            end
                        end else if (!r_phase_falling) begin
                            r_ovf_cnt       <= '0;
                            r_first_stamp   <= in_cap;
                            r_dir_backward  <= !in_dir;
                            r_phase_falling <= 1'b1;
                            r_out_valid     <= 1'b1;
                            r_out_speed     <= r_pub;
                            r_out_upd       <= 1'b0;
                            r_out_to        <= 1'b0;
                        end else begin
                            r_cap   <= in_cap;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    // Only used when more than one overflow lies inside the pulse.
                    r_prod  <= WIDTH_W'(r_wrap_span) * WIDTH_W'(r_ovf_cnt - 1'b1);
                    r_state <= S_WIDTH;
                end
                S_WIDTH: begin
                    r_state <= S_DIV_SPD;
                end
                S_DIV_SPD: begin
                    if (div_done) begin
                        r_single <= single;
                        r_sum    <= r_sum + SUM_W'(single);
                        r_state  <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (group_end) begin
                        r_cnt     <= '0;
                        r_avg_neg <= acc_neg;
                        r_acc_mag <= acc_mag[MAG_W-1:0];
                        r_state   <= S_AVG_MUL;
                    end else begin
                        r_cnt           <= n_cnt;
                        r_phase_falling <= 1'b0;
                        r_out_valid     <= 1'b1;
                        r_out_speed     <= r_pub;
                        r_out_upd       <= 1'b0;
                        r_out_to        <= 1'b0;
                        r_state         <= S_IDLE;
                    end
                end
                S_AVG_MUL: begin
                    r_avg_q <= avg_prod[RECIP_SH +: CONST_W];
                    r_state <= S_AVG;
                end
                S_AVG: begin
                    r_prev_avg      <= avg;
                    r_primed        <= 1'b1;
                    r_sum           <= '0;
                    r_phase_falling <= 1'b0;
                    r_out_valid     <= 1'b1;
                    r_out_to        <= 1'b0;
                    if (pass) begin
                        r_pub       <= avg;
                        r_out_speed <= avg;
                        r_out_upd   <= 1'b1;
                    end else begin
                        r_out_speed <= r_pub;
                        r_out_upd   <= 1'b0;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(M_TDATA_W - SPEED_W)'(0), r_out_speed};
    assign m_axis_tuser  = {r_out_to, r_out_upd};

    // The divider only runs while the sequencer waits on it.
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !div_busy)
        else $error("divider busy while sequencer is idle");

    a_timeout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata[SPEED_W-1:0] == '0))
        else $error("timeout result carries a nonzero speed");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("update and timeout flagged together");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CNT_W'(FILTER_LEN))
        else $error("sample count out of range");

    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (in_op == OP_OVERFLOW)) |=> m_axis_tvalid)
        else $error("overflow tick gave no result on the next cycle");

endmodule
